// ===== hw/rtl/hml_pkg.sv =====
// Package for the hash multimap: payload structs, FSM encodings, status codes,
// hash constants and default sizes. No dependencies.
package hml_pkg;

    localparam int KEY_SLOTS_DEF         = 1024;
    localparam int INFO_SLOTS_DEF        = 4096;
    localparam int MAX_INFOS_PER_KEY_DEF = 64;

    localparam logic [63:0] MIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int          MIX_SHIFT = 33;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_KEYS_FULL = 2'd1,
        ST_POOL_FULL = 2'd2,
        ST_LIST_FULL = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        OP_ADD    = 1'b0,
        OP_LOOKUP = 1'b1
    } opcode_t;

    typedef enum logic [0:0] {
        F_IDLE,
        F_MUL
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE_RD,
        B_PROBE_CHK,
        B_LIST_RD,
        B_LIST_CHK
    } back_state_t;

    typedef struct packed {
        logic [0:0]  opcode;
        logic [63:0] key;
        logic [63:0] info_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [6:0]  info_count;
        logic [63:0] result_info;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [0:0]  opcode;
        logic [63:0] key;
        logic [63:0] info_value;
        logic [63:0] hash;
    } job_t;

endpackage

// ===== hw/rtl/hash_multimap_insert_lookup.sv =====
// Top level of the hash multimap: front hash unit, job queue, table engine.
// Uses hml_pkg, hml_front, hml_queue, hml_back.
//
// Usage: a command (opcode, key, info_value) is taken at a clock edge where
// start is high and busy is low. Each result appears on result for one cycle
// with result_valid high; the receiver must take it then. An add gives one
// result; a lookup gives one result per stored info word, newest first, or
// one not-found result, with last set on the final one.
// Flow: hashing (two 64-bit multiplies on a shared 32x32 multiplier), the
// job queue, then probe steps on the slot RAM, each a read state and a check
// state, then the registered result for an add or a miss. A lookup hit adds
// a read and a check state per info word on the pool RAM. busy stays high
// from the transfer of a command until the cycle its last result is on the
// ports, so one command is in flight at a time.
// After reset, busy stays high while the slot table is cleared one entry per
// cycle. Results cannot be stalled.
module hash_multimap_insert_lookup #(
    parameter int KEY_SLOTS         = hml_pkg::KEY_SLOTS_DEF,
    parameter int INFO_SLOTS        = hml_pkg::INFO_SLOTS_DEF,
    parameter int MAX_INFOS_PER_KEY = hml_pkg::MAX_INFOS_PER_KEY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  hml_pkg::cmd_t    cmd,
    output logic             result_valid,
    output hml_pkg::result_t result
);
    import hml_pkg::*;

    logic accept;
    logic f_push, f_busy;
    logic q_pop, q_empty;
    logic b_busy;
    job_t f_job, q_head;

    assign accept = start && !busy;
    assign busy   = f_busy || !q_empty || b_busy;

    hml_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .cmd    (cmd),
        .push   (f_push),
        .job    (f_job),
        .busy   (f_busy)
    );

    hml_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (f_push),
        .push_job (f_job),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    hml_back #(
        .KEY_SLOTS         (KEY_SLOTS),
        .INFO_SLOTS        (INFO_SLOTS),
        .MAX_INFOS_PER_KEY (MAX_INFOS_PER_KEY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .empty        (q_empty),
        .pop          (q_pop),
        .busy         (b_busy),
        .result_valid (result_valid),
        .result       (result)
    );
endmodule

// ===== hw/rtl/hml_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/hml_front.sv =====
// Front end: accepts commands and computes the 64-bit finalizer hash with a
// shared 32x32 multiplier. Uses hml_pkg.
module hml_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  hml_pkg::cmd_t cmd,
    output logic          push,
    output hml_pkg::job_t job,
    output logic          busy
);
    import hml_pkg::*;

    front_state_t state_reg, state_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         pass_reg, pass_next;
    logic [63:0]  v_reg, v_next;
    logic [63:0]  acc_reg, acc_next;
    logic [63:0]  prod_reg, prod_next;
    cmd_t         cmd_reg, cmd_next;
    logic [63:0]  cst;
    logic [31:0]  op_a, op_b;
    logic [63:0]  m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        pass_reg <= pass_next;
        v_reg    <= v_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        cmd_reg  <= cmd_next;
    end

    always_comb
    begin
        cst  = pass_reg ? MIX_C2 : MIX_C1;
        op_a = (cnt_reg == 2'd2) ? v_reg[63:32] : v_reg[31:0];
        op_b = (cnt_reg == 2'd1) ? cst[63:32] : cst[31:0];
        m    = acc_reg + {prod_reg[31:0], 32'd0};

        state_next = state_reg;
        cnt_next   = cnt_reg;
        pass_next  = pass_reg;
        v_next     = v_reg;
        acc_next   = acc_reg;
        prod_next  = 64'(op_a) * 64'(op_b);
        cmd_next   = cmd_reg;
        push       = 1'b0;
        job.opcode     = cmd_reg.opcode;
        job.key        = cmd_reg.key;
        job.info_value = cmd_reg.info_value;
        job.hash       = m ^ (m >> MIX_SHIFT);

        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    v_next     = cmd.key ^ (cmd.key >> MIX_SHIFT);
                    cnt_next   = 2'd0;
                    pass_next  = 1'b0;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                cnt_next = cnt_reg + 2'd1;
                case (cnt_reg)
                    2'd1:
                    begin
                        acc_next = prod_reg;
                    end
                    2'd2:
                    begin
                        acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                    end
                    2'd3:
                    begin
                        v_next = m ^ (m >> MIX_SHIFT);
                        if (pass_reg)
                        begin
                            push       = 1'b1;
                            state_next = F_IDLE;
                        end
                        else
                        begin
                            pass_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != F_IDLE);
endmodule

// ===== hw/rtl/hml_queue.sv =====
// Two-entry job queue between the hash front end and the table engine.
// Uses hml_pkg.
module hml_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hml_pkg::job_t push_job,
    input  logic          pop,
    output hml_pkg::job_t head,
    output logic          empty
);
    import hml_pkg::*;

    job_t       q_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] n_reg, n_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg  <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            n_reg  <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && n_reg != 2'd2)
        begin
            q_reg[wp_reg] <= push_job;
        end
    end

    always_comb
    begin
        logic do_push;
        logic do_pop;
        do_push = push && (n_reg != 2'd2);
        do_pop  = pop && (n_reg != 2'd0);
        wp_next = do_push ? ~wp_reg : wp_reg;
        rp_next = do_pop ? ~rp_reg : rp_reg;
        n_next  = n_reg + 2'(do_push) - 2'(do_pop);
    end

    assign head  = q_reg[rp_reg];
    assign empty = (n_reg == 2'd0);
endmodule

// ===== hw/rtl/hml_back.sv =====
// Back end: clears the slot table after reset, then runs linear probing,
// add and lookup list walks on the slot and pool RAMs. Uses hml_pkg, hml_ram.
module hml_back #(
    parameter int KEY_SLOTS         = hml_pkg::KEY_SLOTS_DEF,
    parameter int INFO_SLOTS        = hml_pkg::INFO_SLOTS_DEF,
    parameter int MAX_INFOS_PER_KEY = hml_pkg::MAX_INFOS_PER_KEY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hml_pkg::job_t    head,
    input  logic             empty,
    output logic             pop,
    output logic             busy,
    output logic             result_valid,
    output hml_pkg::result_t result
);
    import hml_pkg::*;

    localparam int SW  = $clog2(KEY_SLOTS);
    localparam int IW  = $clog2(INFO_SLOTS);
    localparam int PW  = IW + 1;
    localparam int KW  = SW + 1;
    localparam int SWD = 1 + 64 + 7 + IW;
    localparam int PWD = 64 + IW;

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [SW-1:0] addr_reg, addr_next;
    logic [SW-1:0] pcnt_reg, pcnt_next;
    logic [PW-1:0] pool_used_reg, pool_used_next;
    logic [KW-1:0] keys_used_reg, keys_used_next;
    logic [IW-1:0] lp_reg, lp_next;
    logic [6:0]    lk_reg, lk_next;
    logic [6:0]    ln_reg, ln_next;
    logic          rv_reg, rv_next;
    result_t       res_reg, res_next;

    logic           s_we;
    logic [SW-1:0]  s_raddr;
    logic [SWD-1:0] s_wdata, s_rdata;
    logic           p_we;
    logic [IW-1:0]  p_raddr;
    logic [PWD-1:0] p_wdata, p_rdata;

    logic          r_valid;
    logic [63:0]   r_key;
    logic [6:0]    r_count;
    logic [IW-1:0] r_head;

    hml_ram #(.WIDTH(SWD), .DEPTH(KEY_SLOTS)) u_slot (
        .clk   (clk),
        .we    (s_we),
        .waddr (addr_reg),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    hml_ram #(.WIDTH(PWD), .DEPTH(INFO_SLOTS)) u_pool (
        .clk   (clk),
        .we    (p_we),
        .waddr (pool_used_reg[IW-1:0]),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    assign {r_valid, r_key, r_count, r_head} = s_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            addr_reg      <= '0;
            pool_used_reg <= '0;
            keys_used_reg <= '0;
            rv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            pool_used_reg <= pool_used_next;
            keys_used_reg <= keys_used_next;
            rv_reg        <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        pcnt_reg <= pcnt_next;
        lp_reg   <= lp_next;
        lk_reg   <= lk_next;
        ln_reg   <= ln_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        addr_next      = addr_reg;
        pcnt_next      = pcnt_reg;
        pool_used_next = pool_used_reg;
        keys_used_next = keys_used_reg;
        lp_next        = lp_reg;
        lk_next        = lk_reg;
        ln_next        = ln_reg;
        rv_next        = 1'b0;
        res_next       = res_reg;
        pop            = 1'b0;
        s_we           = 1'b0;
        s_wdata        = '0;
        s_raddr        = addr_reg;
        p_we           = 1'b0;
        p_wdata        = {job_reg.info_value, IW'(0)};
        p_raddr        = lp_reg;

        case (state_reg)
            B_CLEAR:
            begin
                s_we      = 1'b1;
                addr_next = addr_reg + SW'(1);
                if (addr_reg == SW'(KEY_SLOTS - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    job_next   = head;
                    addr_next  = head.hash[SW-1:0];
                    pcnt_next  = '0;
                    state_next = B_PROBE_RD;
                end
            end
            B_PROBE_RD:
            begin
                state_next = B_PROBE_CHK;
            end
            B_PROBE_CHK:
            begin
                res_next.status      = ST_OK;
                res_next.found       = 1'b0;
                res_next.info_count  = 7'd0;
                res_next.result_info = 64'd0;
                res_next.last        = 1'b1;
                if (r_valid && r_key == job_reg.key)
                begin
                    res_next.found      = 1'b1;
                    res_next.info_count = r_count;
                    if (job_reg.opcode == OP_LOOKUP)
                    begin
                        lp_next    = r_head;
                        lk_next    = 7'd0;
                        ln_next    = r_count;
                        state_next = B_LIST_RD;
                    end
                    else
                    begin
                        rv_next    = 1'b1;
                        state_next = B_IDLE;
                        if (r_count >= 7'(MAX_INFOS_PER_KEY))
                        begin
                            res_next.status = ST_LIST_FULL;
                        end
                        else if (pool_used_reg >= PW'(INFO_SLOTS))
                        begin
                            res_next.status = ST_POOL_FULL;
                        end
                        else
                        begin
                            p_we    = 1'b1;
                            p_wdata = {job_reg.info_value, r_head};
                            s_we    = 1'b1;
                            s_wdata = {1'b1, r_key, r_count + 7'd1,
                                       pool_used_reg[IW-1:0]};
                            pool_used_next      = pool_used_reg + PW'(1);
                            res_next.info_count = r_count + 7'd1;
                        end
                    end
                end
                else if (r_valid && pcnt_reg != SW'(KEY_SLOTS - 1))
                begin
                    addr_next  = addr_reg + SW'(1);
                    pcnt_next  = pcnt_reg + SW'(1);
                    state_next = B_PROBE_RD;
                end
                else
                begin
                    rv_next    = 1'b1;
                    state_next = B_IDLE;
                    if (job_reg.opcode == OP_ADD)
                    begin
                        if (r_valid || keys_used_reg >= KW'(KEY_SLOTS))
                        begin
                            res_next.status = ST_KEYS_FULL;
                        end
                        else if (pool_used_reg >= PW'(INFO_SLOTS))
                        begin
                            res_next.status = ST_POOL_FULL;
                        end
                        else
                        begin
                            p_we    = 1'b1;
                            s_we    = 1'b1;
                            s_wdata = {1'b1, job_reg.key, 7'd1, pool_used_reg[IW-1:0]};
                            pool_used_next      = pool_used_reg + PW'(1);
                            keys_used_next      = keys_used_reg + KW'(1);
                            res_next.info_count = 7'd1;
                        end
                    end
                end
            end
            B_LIST_RD:
            begin
                state_next = B_LIST_CHK;
            end
            B_LIST_CHK:
            begin
                rv_next              = 1'b1;
                res_next.status      = ST_OK;
                res_next.found       = 1'b1;
                res_next.info_count  = ln_reg;
                res_next.result_info = p_rdata[PWD-1:IW];
                res_next.last        = (lk_reg + 7'd1 == ln_reg);
                lp_next              = p_rdata[IW-1:0];
                lk_next              = lk_reg + 7'd1;
                state_next           = (lk_reg + 7'd1 == ln_reg) ? B_IDLE : B_LIST_RD;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != B_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for hash_multimap_insert_lookup: directed table, then random
// adds and lookups mostly over a small key set, checked against an in-bench multimap model.
// Depends on hml_pkg and the RTL of the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import hml_pkg::*;

    localparam int NKEY = 1024;
    localparam int NPOOL = 4096;
    localparam int MAXL = 64;
    localparam int LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    cmd_t cmd = '0;
    logic result_valid;
    result_t result;

    hash_multimap_insert_lookup dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .result_valid(result_valid), .result(result)
    );

    always #5 clk = ~clk;

    logic [63:0] m_key [NKEY];
    logic        m_valid [NKEY];
    int          m_count [NKEY];
    int          m_head [NKEY];
    logic [63:0] m_info [NPOOL];
    int          m_link [NPOOL];
    int          m_pool_used;
    int          m_keys_used;

    result_t expected_q[$];
    int errors = 0;
    int cycles = 0;
    logic [63:0] key_set [16];

    typedef struct {
        cmd_t    c;
        logic    has_exp;
        result_t r;
    } row_t;

    function automatic logic [63:0] mix64(logic [63:0] v);
        v = v ^ (v >> MIX_SHIFT);
        v = v * MIX_C1;
        v = v ^ (v >> MIX_SHIFT);
        v = v * MIX_C2;
        v = v ^ (v >> MIX_SHIFT);
        return v;
    endfunction

    function automatic result_t mk(status_t st, logic f, int n, logic [63:0] w, logic l);
        result_t r;
        r.status = st;
        r.found = f;
        r.info_count = n[6:0];
        r.result_info = w;
        r.last = l;
        return r;
    endfunction

    task automatic predict_multimap(cmd_t c);
        int home;
        int s;
        int p;
        int n;
        logic hit;
        home = int'(mix64(c.key) % NKEY);
        s = NKEY;
        hit = 1'b0;
        for (int i = 0; i < NKEY; i++)
        begin
            int t;
            t = (home + i) % NKEY;
            if (!m_valid[t])
            begin
                s = t;
                break;
            end
            if (m_key[t] == c.key)
            begin
                s = t;
                hit = 1'b1;
                break;
            end
        end
        if (c.opcode == OP_LOOKUP)
        begin
            if (!hit)
                expected_q.push_back(mk(ST_OK, 0, 0, 0, 1));
            else
            begin
                n = m_count[s];
                p = m_head[s];
                for (int k = 0; k < n; k++)
                begin
                    expected_q.push_back(mk(ST_OK, 1, n, m_info[p], k + 1 == n));
                    p = m_link[p];
                end
            end
        end
        else if (hit)
        begin
            n = m_count[s];
            if (n >= MAXL)
                expected_q.push_back(mk(ST_LIST_FULL, 1, n, 0, 1));
            else if (m_pool_used >= NPOOL)
                expected_q.push_back(mk(ST_POOL_FULL, 1, n, 0, 1));
            else
            begin
                m_info[m_pool_used] = c.info_value;
                m_link[m_pool_used] = m_head[s];
                m_head[s] = m_pool_used;
                m_pool_used++;
                m_count[s] = n + 1;
                expected_q.push_back(mk(ST_OK, 1, n + 1, 0, 1));
            end
        end
        else if (s >= NKEY || m_keys_used >= NKEY)
            expected_q.push_back(mk(ST_KEYS_FULL, 0, 0, 0, 1));
        else if (m_pool_used >= NPOOL)
            expected_q.push_back(mk(ST_POOL_FULL, 0, 0, 0, 1));
        else
        begin
            m_info[m_pool_used] = c.info_value;
            m_link[m_pool_used] = 0;
            m_valid[s] = 1'b1;
            m_key[s] = c.key;
            m_count[s] = 1;
            m_head[s] = m_pool_used;
            m_pool_used++;
            m_keys_used++;
            expected_q.push_back(mk(ST_OK, 0, 1, 0, 1));
        end
    endtask

    task automatic issue(cmd_t c);
        int gap;
        gap = $urandom_range(0, 11);
        repeat (gap) @(posedge clk);
        start <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_multimap(c);
        start <= 1'b0;
        @(posedge clk);
    endtask

    function automatic cmd_t mkcmd(opcode_t op, logic [63:0] k, logic [63:0] v);
        cmd_t c;
        c.opcode = op;
        c.key = k;
        c.info_value = v;
        return c;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        if (rst_n && result_valid)
        begin
            if (expected_q.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result %p", result);
                errors++;
            end
            else
            begin
                result_t e;
                e = expected_q.pop_front();
                if (result !== e)
                begin
                    if (errors < 10)
                        $display("mismatch: exp %p got %p", e, result);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        cmd_t c;
        result_t got;
        int wait_cycles;
        for (int i = 0; i < NKEY; i++)
            m_valid[i] = 1'b0;
        m_pool_used = 0;
        m_keys_used = 0;
        for (int i = 0; i < 16; i++)
            key_set[i] = {$urandom, $urandom};
        key_set[0] = '0;
        key_set[1] = '1;

        rows.push_back('{mkcmd(OP_LOOKUP, 64'd0, 64'd0), 1, mk(ST_OK, 0, 0, 0, 1)});
        rows.push_back('{mkcmd(OP_ADD, 64'd0, '1), 1, mk(ST_OK, 0, 1, 0, 1)});
        rows.push_back('{mkcmd(OP_ADD, 64'd0, 64'd0), 1, mk(ST_OK, 1, 2, 0, 1)});
        rows.push_back('{mkcmd(OP_LOOKUP, 64'd0, '1), 1, mk(ST_OK, 1, 2, 0, 0)});
        rows.push_back('{mkcmd(OP_ADD, '1, 64'h5555_5555_5555_5555), 1,
                         mk(ST_OK, 0, 1, 0, 1)});
        rows.push_back('{mkcmd(OP_LOOKUP, '1, 64'd0), 1,
                         mk(ST_OK, 1, 1, 64'h5555_5555_5555_5555, 1)});
        rows.push_back('{mkcmd(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'd0), 1,
                         mk(ST_OK, 0, 0, 0, 1)});
        // list fill to the per-key limit, then one rejected add
        for (int i = 0; i < MAXL; i++)
            rows.push_back('{mkcmd(OP_ADD, key_set[2], {$urandom, $urandom}), 0, '0});
        rows.push_back('{mkcmd(OP_ADD, key_set[2], 64'd1), 1, mk(ST_LIST_FULL, 1, 64, 0, 1)});
        rows.push_back('{mkcmd(OP_LOOKUP, key_set[2], 64'd0), 0, '0});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.has_exp)
            begin
                // typed-in value must agree with the model on the first result
                while (expected_q.size() != 0) @(posedge clk);
                issue(rw.c);
                got = expected_q[0];
                if (got !== rw.r)
                begin
                    errors++;
                    $display("table row %0d: exp %p model %p", i, rw.r, got);
                end
            end
            else
                issue(rw.c);
        end

        for (int n = 0; n < 30; n++)
        begin
            if (n == 15)
                while (expected_q.size() != 0) @(posedge clk);
            c.opcode = ($urandom_range(0, 2) == 0) ? OP_LOOKUP : OP_ADD;
            c.key = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom}
                                                : key_set[$urandom_range(0, 15)];
            c.info_value = {$urandom, $urandom};
            issue(c);
        end

        wait_cycles = 0;
        while (expected_q.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
